// ===== hw/rtl/first_fit_block_allocator_core_assert.svh =====
// Assertion macros used by the allocator core RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Checks that the consequent holds whenever the antecedent holds, outside reset.
`define FFA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator sequencing check failed");

`endif

// ===== hw/rtl/ffa_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
package ffa_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned FirstW = 10;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [FirstW-1:0]  first_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgHeapBase    = cfg_idx_t'(0);
  localparam cfg_idx_t CfgBlocksInUse = cfg_idx_t'(1);

  localparam int unsigned BlocksW     = 11;
  localparam int unsigned BlocksReset = 1024;

  typedef struct packed {
    logic   idle;
    logic   res_valid;
    logic   granted;
    addr_t  addr;
    first_t first;
  } ffa_status_t;

endpackage

// ===== hw/rtl/first_fit_block_allocator_core.sv =====
// Top level of the first-fit contiguous block allocator.
// A request carries a size in bytes on request_bytes_i and is taken when
// in_valid_i is high and in_stall_o is low. The block rounds the size up to
// whole blocks, scans the taken-map from block 0 for the lowest free run of
// that length, marks the run taken and returns one result per request on
// granted_o, block_address_o and first_block_o, taken when out_valid_o is high
// and out_stall_i is low. A zero size, a size beyond the heap or a heap with
// no fitting run gives granted_o low with zero address and index.
// A granted request scans the map entries up to the last block of the run,
// then marks each block of the run taken before its result is valid; a
// failed scan reads every entry of the heap, and a zero size skips the scan.
// The map has a single read port and a single write port. Registers heap_base
// and blocks_in_use are written through cfg_we_i; the user must write them
// only while the block is idle, which the block itself does not enforce.
// After reset the map is cleared to free, one entry a cycle, over all
// MAX_BLOCKS entries, and in_stall_o stays high until that pass ends.
// A finished result sits in an output register, so a stalled receiver holds
// the result while the next request is already taken and scanned.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ffa_pkg::addr_t        request_bytes_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output ffa_pkg::addr_t        block_address_o,
  output ffa_pkg::first_t       first_block_o,
  input  logic                  cfg_we_i,
  input  ffa_pkg::cfg_idx_t     cfg_index_i,
  input  ffa_pkg::addr_t        cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  ffa_pkg::addr_t                  heap_base_q;
  logic [ffa_pkg::BlocksW-1:0]     blocks_q;
  logic [CntW-1:0]                 limit;
  ffa_pkg::ffa_status_t            eng_status;
  logic                            in_accept;
  logic                            out_load;
  logic                            out_valid_q;
  logic                            granted_q;
  ffa_pkg::addr_t                  addr_q;
  ffa_pkg::first_t                 first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      blocks_q    <= ffa_pkg::BlocksW'(ffa_pkg::BlocksReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffa_pkg::CfgHeapBase:    heap_base_q <= cfg_wdata_i;
        ffa_pkg::CfgBlocksInUse: blocks_q    <= cfg_wdata_i[ffa_pkg::BlocksW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (32'(blocks_q) > 32'(MAX_BLOCKS)) begin
      limit = CntW'(MAX_BLOCKS);
    end else begin
      limit = CntW'(blocks_q);
    end
  end

  assign in_stall_o = !eng_status.idle;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = eng_status.res_valid && (!out_valid_q || !out_stall_i);

  ffa_engine #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .req_bytes_i (request_bytes_i),
    .limit_i     (limit),
    .heap_base_i (heap_base_q),
    .res_ack_i   (out_load),
    .status_o    (eng_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_q <= eng_status.granted;
      addr_q    <= eng_status.addr;
      first_q   <= eng_status.first;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign block_address_o = addr_q;
  assign first_block_o   = first_q;

`include "first_fit_block_allocator_core_assert.svh"

  `FFA_ASSERT_IMPLIES(a_fail_is_zero, out_valid_o && !granted_o, ~|{block_address_o, first_block_o})
  `FFA_ASSERT_NEXT(a_accept_busy, in_accept, in_stall_o)
  `FFA_ASSERT_IMPLIES(a_result_while_busy, eng_status.res_valid, in_stall_o)

endmodule

// ===== hw/rtl/ffa_map_ram.sv =====
// Taken-map memory: one write port and one registered read port.
module ffa_map_ram #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ffa_engine.sv =====
// First-fit scan and mark sequencer around the taken-map memory.
module ffa_engine #(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096,
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ffa_pkg::addr_t      req_bytes_i,
  input  logic [CntW-1:0]     limit_i,
  input  ffa_pkg::addr_t      heap_base_i,
  input  logic                res_ack_i,
  output ffa_pkg::ffa_status_t status_o
);

  localparam int unsigned AW   = $clog2(MAX_BLOCKS);
  localparam int unsigned RunW = $clog2(MAX_BLOCKS) + $clog2(BLOCK_BYTES) + 1;
  localparam int unsigned CmpW = (RunW > ffa_pkg::AddrW + 1) ? RunW : ffa_pkg::AddrW + 1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StMark,
    StDone
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             rvld_q, rvld_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [RunW-1:0]  run_bytes_q, run_bytes_d;
  logic [CntW-1:0]  start_q, start_d;
  ffa_pkg::addr_t   start_bytes_q, start_bytes_d;
  ffa_pkg::addr_t   req_q, req_d;
  logic [CntW-1:0]  limit_q, limit_d;
  logic             granted_q, granted_d;
  ffa_pkg::addr_t   addr_q, addr_d;
  ffa_pkg::first_t  first_q, first_d;

  logic             ram_we;
  logic             ram_wdata;
  logic             ram_re;
  logic             ram_rdata;
  logic             issue_ok;
  logic [CntW-1:0]  run_inc;
  logic [RunW-1:0]  run_bytes_inc;
  logic             fit;

  ffa_map_ram #(
    .Depth (MAX_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign issue_ok      = (idx_q < limit_q);
  assign run_inc       = run_q + CntW'(1);
  assign run_bytes_inc = run_bytes_q + RunW'(BLOCK_BYTES);
  assign fit           = rvld_q && !ram_rdata && (CmpW'(run_bytes_inc) >= CmpW'(req_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      StClear: begin
        ram_we = 1'b1;
      end
      StMark: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
      end
      StScan: begin
        ram_re = issue_ok;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    rvld_d        = rvld_q;
    run_d         = run_q;
    run_bytes_d   = run_bytes_q;
    start_d       = start_q;
    start_bytes_d = start_bytes_q;
    req_d         = req_q;
    limit_d       = limit_q;
    granted_d     = granted_q;
    addr_d        = addr_q;
    first_d       = first_q;
    unique case (state_q)
      StClear: begin
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(MAX_BLOCKS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          req_d         = req_bytes_i;
          limit_d       = limit_i;
          idx_d         = '0;
          rvld_d        = 1'b0;
          run_d         = '0;
          run_bytes_d   = '0;
          start_d       = '0;
          start_bytes_d = '0;
          granted_d     = 1'b0;
          addr_d        = '0;
          first_d       = '0;
          state_d       = (req_bytes_i == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        rvld_d = issue_ok;
        if (issue_ok) begin
          idx_d = idx_q + CntW'(1);
        end
        if (rvld_q) begin
          if (ram_rdata) begin
            run_d         = '0;
            run_bytes_d   = '0;
            start_d       = start_q + run_inc;
            start_bytes_d = start_bytes_q + ffa_pkg::addr_t'(run_bytes_inc);
          end else if (fit) begin
            idx_d     = start_q;
            run_d     = run_inc;
            rvld_d    = 1'b0;
            granted_d = 1'b1;
            addr_d    = heap_base_i + start_bytes_q;
            first_d   = ffa_pkg::first_t'(start_q);
            state_d   = StMark;
          end else begin
            run_d       = run_inc;
            run_bytes_d = run_bytes_inc;
          end
        end else if (!issue_ok) begin
          state_d = StDone;
        end
      end
      StMark: begin
        idx_d = idx_q + CntW'(1);
        run_d = run_q - CntW'(1);
        if (run_q == CntW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ack_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      idx_q         <= '0;
      rvld_q        <= 1'b0;
      run_q         <= '0;
      run_bytes_q   <= '0;
      start_q       <= '0;
      start_bytes_q <= '0;
      req_q         <= '0;
      limit_q       <= '0;
      granted_q     <= 1'b0;
      addr_q        <= '0;
      first_q       <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      rvld_q        <= rvld_d;
      run_q         <= run_d;
      run_bytes_q   <= run_bytes_d;
      start_q       <= start_d;
      start_bytes_q <= start_bytes_d;
      req_q         <= req_d;
      limit_q       <= limit_d;
      granted_q     <= granted_d;
      addr_q        <= addr_d;
      first_q       <= first_d;
    end
  end

  assign status_o.idle      = (state_q == StIdle);
  assign status_o.res_valid = (state_q == StDone);
  assign status_o.granted   = granted_q;
  assign status_o.addr      = addr_q;
  assign status_o.first     = first_q;

endmodule

// ===== tb/sv/first_fit_block_allocator_core_tb.sv =====
// Testbench for the first-fit block allocator core with its own allocation predictor.
module first_fit_block_allocator_core_tb;

  localparam int unsigned MaxBlocks    = 1024;
  localparam int unsigned BlockBytes   = 4096;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseItems   = 87;
  localparam int unsigned LongHold     = 4000;
  localparam int unsigned FirstHoldAt  = 120;
  localparam int unsigned SecondHoldAt = 380;
  localparam int unsigned CycleLimit   = 4000000;
  localparam ffa_pkg::cfg_idx_t CfgSpare2 = ffa_pkg::cfg_idx_t'(2);
  localparam ffa_pkg::cfg_idx_t CfgSpare3 = ffa_pkg::cfg_idx_t'(3);

  typedef struct packed {
    logic            granted;
    ffa_pkg::addr_t  address;
    ffa_pkg::first_t first;
  } grant_t;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  ffa_pkg::addr_t    request_bytes_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              granted_o;
  ffa_pkg::addr_t    block_address_o;
  ffa_pkg::first_t   first_block_o;
  logic              cfg_we_i        = 1'b0;
  ffa_pkg::cfg_idx_t cfg_index_i     = ffa_pkg::CfgHeapBase;
  ffa_pkg::addr_t    cfg_wdata_i     = '0;

  bit [MaxBlocks-1:0]          taken_map = '0;
  ffa_pkg::addr_t              base_addr = '0;
  logic [ffa_pkg::BlocksW-1:0] heap_blocks = ffa_pkg::BlocksW'(ffa_pkg::BlocksReset);

  ffa_pkg::addr_t pending_sizes[$];
  grant_t         expected_grants[$];
  grant_t         want;
  bit             pace_on = 1'b1;
  int unsigned    gap_left = 0;
  int unsigned    stall_left = 0;
  int unsigned    hold_left = 0;
  int unsigned    stall_draw;
  int unsigned    results_seen = 0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;

  first_fit_block_allocator_core #(
    .MAX_BLOCKS (MaxBlocks),
    .BLOCK_BYTES(BlockBytes)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .request_bytes_i(request_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .block_address_o(block_address_o),
    .first_block_o  (first_block_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  function automatic grant_t predict_allocation(ffa_pkg::addr_t bytes);
    grant_t      res;
    logic [32:0] need;
    int unsigned limit;
    int unsigned run;
    int unsigned start;
    bit          found;
    res = '0;
    need = ({1'b0, bytes} + 33'(BlockBytes - 1)) / BlockBytes;
    limit = (heap_blocks > MaxBlocks) ? MaxBlocks : heap_blocks;
    if (need == 0 || need > limit) return res;
    run = 0;
    start = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < limit && !found; i++) begin
      if (taken_map[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == need) begin
          start = i + 1 - need;
          found = 1'b1;
        end
      end
    end
    if (!found) return res;
    for (int unsigned i = 0; i < need; i++) taken_map[start + i] = 1'b1;
    res.granted = 1'b1;
    res.address = base_addr + ffa_pkg::addr_t'(start * BlockBytes);
    res.first = ffa_pkg::first_t'(start);
    return res;
  endfunction

  function automatic int unsigned draw_idle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!pace_on || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic ffa_pkg::addr_t draw_request_bytes();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = (heap_blocks > MaxBlocks) ? MaxBlocks : heap_blocks;
    if (pick < 5) return '0;
    if (pick < 10) return $urandom();
    if (pick < 20) return ffa_pkg::addr_t'($urandom_range(1, 8) * BlockBytes);
    if (pick < 28) begin
      return ffa_pkg::addr_t'((span + $urandom_range(0, 1)) * BlockBytes
                              - $urandom_range(0, BlockBytes - 1));
    end
    return ffa_pkg::addr_t'($urandom_range(0, 3) * BlockBytes + $urandom_range(1, BlockBytes));
  endfunction

  task automatic write_reg(ffa_pkg::cfg_idx_t idx, ffa_pkg::addr_t data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ffa_pkg::CfgHeapBase: base_addr = data;
      ffa_pkg::CfgBlocksInUse: heap_blocks = data[ffa_pkg::BlocksW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_sizes.size() != 0 || in_valid_i || expected_grants.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      request_bytes_i <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_grants.push_back(predict_allocation(request_bytes_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_sizes.size() > 0) begin
          in_valid_i <= 1'b1;
          request_bytes_i <= pending_sizes.pop_front();
          gap_left <= draw_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_seen == FirstHoldAt || results_seen == SecondHoldAt) begin
          hold_left <= LongHold;
        end
        if (expected_grants.size() == 0) begin
          $error("result with no request pending: granted %0b, address %h, first block %0d",
                 granted_o, block_address_o, first_block_o);
          error_count++;
        end else begin
          want = expected_grants.pop_front();
          if (granted_o !== want.granted) begin
            $error("granted: expected %0b, actual %0b", want.granted, granted_o);
            error_count++;
          end
          if (block_address_o !== want.address) begin
            $error("block_address: expected %h, actual %h", want.address, block_address_o);
            error_count++;
          end
          if (first_block_o !== want.first) begin
            $error("first_block: expected %0d, actual %0d", want.first, first_block_o);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_draw = draw_idle();
        out_stall_i <= (stall_draw > 0);
        stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
      end
    end
  end

  initial begin
    int unsigned    top_used;
    int unsigned    count;
    ffa_pkg::addr_t base;
    ffa_pkg::addr_t noise;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of both registers: full heap at address zero.
    @(negedge clk_i);
    pending_sizes = '{32'h0, 32'hFFFF_FFFF, 32'h1, ffa_pkg::addr_t'(BlockBytes),
                      ffa_pkg::addr_t'(BlockBytes + 1),
                      ffa_pkg::addr_t'(MaxBlocks * BlockBytes),
                      ffa_pkg::addr_t'(MaxBlocks * BlockBytes + 1), 32'h8000_0000};
    wait_idle();

    // A small heap near the top of the address space, so the address wraps.
    write_reg(ffa_pkg::CfgHeapBase, 32'hFFFF_E000);
    write_reg(ffa_pkg::CfgBlocksInUse, 32'hFFFF_F808);
    write_reg(CfgSpare2, 32'hFFFF_FFFF);
    write_reg(CfgSpare3, 32'h0);
    @(negedge clk_i);
    pending_sizes = '{ffa_pkg::addr_t'(3 * BlockBytes), ffa_pkg::addr_t'(2 * BlockBytes),
                      ffa_pkg::addr_t'(BlockBytes), 32'h1};
    wait_idle();

    write_reg(ffa_pkg::CfgBlocksInUse, 32'h0);
    @(negedge clk_i);
    pending_sizes = '{32'h1, ffa_pkg::addr_t'(BlockBytes), 32'h0};
    wait_idle();

    write_reg(ffa_pkg::CfgBlocksInUse, 32'h5555_57FF);
    write_reg(ffa_pkg::CfgHeapBase, 32'h8000_0123);
    @(negedge clk_i);
    pending_sizes = '{ffa_pkg::addr_t'(BlockBytes), ffa_pkg::addr_t'(3 * BlockBytes),
                      32'hFFFF_FFFF};
    wait_idle();

    write_reg(ffa_pkg::CfgBlocksInUse, 32'hFFFF_F801);
    @(negedge clk_i);
    pending_sizes = '{32'h1};
    wait_idle();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      top_used = 0;
      for (int unsigned b = 0; b < MaxBlocks; b++) begin
        if (taken_map[b]) top_used = b + 1;
      end
      if (phase == RandomPhases - 1) begin
        count = $urandom_range(MaxBlocks + 1, 2047);
      end else if (phase == RandomPhases - 2) begin
        count = MaxBlocks;
      end else begin
        count = top_used + $urandom_range(4, 160);
        if (count > MaxBlocks) count = MaxBlocks;
      end
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = 32'hFFFF_F000;
        2: base = $urandom() & 32'hFFFF_F000;
        default: base = $urandom();
      endcase
      noise = $urandom();
      write_reg(ffa_pkg::CfgHeapBase, base);
      write_reg(ffa_pkg::CfgBlocksInUse,
                {noise[31:ffa_pkg::BlocksW], count[ffa_pkg::BlocksW-1:0]});
      write_reg((phase % 2) ? CfgSpare3 : CfgSpare2, $urandom());
      @(negedge clk_i);
      pace_on = (phase % 3 != 1);
      for (int unsigned n = 0; n < PhaseItems; n++) pending_sizes.push_back(draw_request_bytes());
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
